// ----- rtl/core/ar3d_pkg.sv -----
// Shared types, constants and tables for the axis rotation pipeline.
package ar3d_pkg;

  localparam int CORDIC_STAGES = 20;
  localparam int STAGE_IDX_W   = 5;
  localparam int CORD_W        = 34;

  localparam logic signed [17:0] ANG_FULL    = 18'sd23040;
  localparam logic signed [17:0] ANG_HALF    = 18'sd11520;
  localparam logic signed [17:0] ANG_QUARTER = 18'sd5760;
  localparam logic [26:0]        ANG_TO_RAD  = 27'd74961321;
  localparam logic signed [CORD_W-1:0] GAIN_INV = CORD_W'(652032874);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    axis_t              cmd;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [15:0] angle;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    logic                     valid;
    axis_t                    cmd;
    logic signed [31:0]       vx;
    logic signed [31:0]       vy;
    logic signed [31:0]       vz;
    logic                     neg;
    logic signed [CORD_W-1:0] cx;
    logic signed [CORD_W-1:0] cy;
    logic signed [CORD_W-1:0] cz;
  } cordic_t;

  function automatic logic signed [CORD_W-1:0] atan_q30(input logic [STAGE_IDX_W-1:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h3243F6A8;
      5'd1:  t = 32'h1DAC6705;
      5'd2:  t = 32'h0FADBAFC;
      5'd3:  t = 32'h07F56EA6;
      5'd4:  t = 32'h03FEAB76;
      5'd5:  t = 32'h01FFD55B;
      5'd6:  t = 32'h00FFFAAA;
      5'd7:  t = 32'h007FFF55;
      5'd8:  t = 32'h003FFFEA;
      5'd9:  t = 32'h001FFFFD;
      5'd10: t = 32'h000FFFFF;
      5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF;
      5'd13: t = 32'h0001FFFF;
      5'd14: t = 32'h0000FFFF;
      5'd15: t = 32'h00007FFF;
      5'd16: t = 32'h00003FFF;
      5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF;
      5'd19: t = 32'h000007FF;
      5'd20: t = 32'h000003FF;
      5'd21: t = 32'h000001FF;
      5'd22: t = 32'h000000FF;
      5'd23: t = 32'h0000007F;
      5'd24: t = 32'h0000003F;
      5'd25: t = 32'h0000001F;
      5'd26: t = 32'h0000000F;
      5'd27: t = 32'h00000008;
      5'd28: t = 32'h00000004;
      5'd29: t = 32'h00000002;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return $signed({{(CORD_W-32){1'b0}}, t});
  endfunction

endpackage

// ----- rtl/core/ar3d_angle.sv -----
// Angle reduction to a quarter turn and conversion to Q2.30 radians.
module ar3d_angle import ar3d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    req_beat,
  input  req_t    req,
  output cordic_t cell_in
);

  logic              s1_valid;
  axis_t             s1_cmd;
  logic signed [31:0] s1_vx, s1_vy, s1_vz;
  logic              s1_neg;
  logic              s1_sign;
  logic [12:0]       s1_mag;

  logic signed [17:0] r;
  logic               fold;
  logic [39:0]        prod;
  logic [31:0]        zmag;

  always_comb begin
    r = 18'(req.angle);
    fold = 1'b0;
    if (r < 0) begin
      r = r + ANG_FULL;
      if (r < 0) begin
        r = r + ANG_FULL;
      end
    end else if (r >= ANG_FULL) begin
      r = r - ANG_FULL;
    end
    if (r > ANG_HALF) begin
      r = r - ANG_FULL;
    end
    if (r > ANG_QUARTER) begin
      r = r - ANG_HALF;
      fold = 1'b1;
    end else if (r < -ANG_QUARTER) begin
      r = r + ANG_HALF;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req_beat;
    end
    if (en) begin
      s1_cmd  <= req.cmd;
      s1_vx   <= req.in_x;
      s1_vy   <= req.in_y;
      s1_vz   <= req.in_z;
      s1_neg  <= fold;
      s1_sign <= r[17];
      s1_mag  <= r[17] ? 13'(-r) : 13'(r);
    end
  end

  assign prod = 40'(s1_mag) * 40'(ANG_TO_RAD) + 40'd128;
  assign zmag = prod[39:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_in.valid <= 1'b0;
    end else if (en) begin
      cell_in.valid <= s1_valid;
    end
    if (en) begin
      cell_in.cmd <= s1_cmd;
      cell_in.vx  <= s1_vx;
      cell_in.vy  <= s1_vy;
      cell_in.vz  <= s1_vz;
      cell_in.neg <= s1_neg;
      cell_in.cx  <= GAIN_INV;
      cell_in.cy  <= '0;
      cell_in.cz  <= s1_sign ? -$signed({2'b00, zmag}) : $signed({2'b00, zmag});
    end
  end

endmodule

// ----- rtl/core/ar3d_cell.sv -----
// One CORDIC rotation step with its pipeline register.
module ar3d_cell import ar3d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [STAGE_IDX_W-1:0] idx,
  input  cordic_t                prev,
  output cordic_t                cur
);

  logic signed [CORD_W-1:0] dx, dy, t;

  assign dx = prev.cy >>> idx;
  assign dy = prev.cx >>> idx;
  assign t  = atan_q30(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
    if (en) begin
      cur.cmd <= prev.cmd;
      cur.vx  <= prev.vx;
      cur.vy  <= prev.vy;
      cur.vz  <= prev.vz;
      cur.neg <= prev.neg;
      if (!prev.cz[CORD_W-1]) begin
        cur.cx <= prev.cx - dx;
        cur.cy <= prev.cy + dy;
        cur.cz <= prev.cz - t;
      end else begin
        cur.cx <= prev.cx + dx;
        cur.cy <= prev.cy - dy;
        cur.cz <= prev.cz + t;
      end
    end
  end

endmodule

// ----- rtl/core/ar3d_rotate.sv -----
// Products with sine and cosine, rounding, saturation and the output register.
module ar3d_rotate import ar3d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cordic_t last,
  output logic    rsp_valid,
  output rsp_t    rsp
);

  logic signed [31:0] s, c, p, q;

  logic               m_valid;
  axis_t              m_cmd;
  logic signed [31:0] m_vx, m_vy, m_vz;
  logic signed [63:0] pc, qs, ps, qc;

  logic signed [65:0] sum_p, sum_q;
  logic signed [32:0] sat_p, sat_q;
  rsp_t               rsp_next;

  function automatic logic signed [32:0] clip32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return {1'b1, 32'h7FFFFFFF};
    end else if (v < -36'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  assign s = last.neg ? 32'(-last.cy) : 32'(last.cy);
  assign c = last.neg ? 32'(-last.cx) : 32'(last.cx);

  always_comb begin
    unique case (last.cmd)
      AXIS_X: begin
        p = last.vy;
        q = last.vz;
      end
      AXIS_Y: begin
        p = last.vz;
        q = last.vx;
      end
      AXIS_Z: begin
        p = last.vx;
        q = last.vy;
      end
      AXIS_NONE: begin
        p = last.vx;
        q = last.vy;
      end
      default: begin
        p = last.vx;
        q = last.vy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= last.valid;
    end
    if (en) begin
      m_cmd <= last.cmd;
      m_vx  <= last.vx;
      m_vy  <= last.vy;
      m_vz  <= last.vz;
      pc    <= p * c;
      qs    <= q * s;
      ps    <= p * s;
      qc    <= q * c;
    end
  end

  assign sum_p = 66'(pc) - 66'(qs) + 66'sd536870912;
  assign sum_q = 66'(ps) + 66'(qc) + 66'sd536870912;
  assign sat_p = clip32(sum_p[65:30]);
  assign sat_q = clip32(sum_q[65:30]);

  always_comb begin
    rsp_next.out_x     = m_vx;
    rsp_next.out_y     = m_vy;
    rsp_next.out_z     = m_vz;
    rsp_next.saturated = 1'b0;
    unique case (m_cmd)
      AXIS_X: begin
        rsp_next.out_y     = sat_p[31:0];
        rsp_next.out_z     = sat_q[31:0];
        rsp_next.saturated = sat_p[32] | sat_q[32];
      end
      AXIS_Y: begin
        rsp_next.out_z     = sat_p[31:0];
        rsp_next.out_x     = sat_q[31:0];
        rsp_next.saturated = sat_p[32] | sat_q[32];
      end
      AXIS_Z: begin
        rsp_next.out_x     = sat_p[31:0];
        rsp_next.out_y     = sat_q[31:0];
        rsp_next.saturated = sat_p[32] | sat_q[32];
      end
      AXIS_NONE: begin
        rsp_next.saturated = 1'b0;
      end
      default: begin
        rsp_next.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= m_valid;
    end
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/core/axis_rotation_3d.sv -----
// Top level: rotation of a Q16.16 vector about the x, y or z axis.
//
// Request channel req_valid / req_stall / req carries cmd (axis), the vector
// and the angle in 1/64 degree. Response channel rsp_valid / rsp_stall / rsp
// carries the rotated vector and the saturation flag. A beat moves on a
// channel at a clock edge with valid high and stall low.
// The reduced angle is registered, then the angle scaled to radians, then the
// state after each CORDIC cell in the chain, then the 32x32 products, and last
// the rounded and saturated result in the output register. A new request is
// taken every cycle unless the chain holds, one result per request.
// Every stage advances together; while the output register holds a beat and
// rsp_stall is high the whole chain holds and req_stall is raised, and it
// resumes at once when the response is taken.
// Synchronous reset clears all stage valid flags; no clearing pass is needed.
module axis_rotation_3d import ar3d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic    en;
  cordic_t chain [CORDIC_STAGES+1];

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  ar3d_angle u_angle (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .req_beat (req_valid),
    .req      (req),
    .cell_in  (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ar3d_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .idx  (STAGE_IDX_W'(g)),
      .prev (chain[g]),
      .cur  (chain[g+1])
    );
  end

  ar3d_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .last      (chain[CORDIC_STAGES]),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ----- sim/axis_rotation_3d_tb.sv -----
// Self-checking testbench for axis_rotation_3d: directed and random beats vs a CORDIC predictor.
`timescale 1ns / 100ps

module axis_rotation_3d_tb;
  import ar3d_pkg::*;

  localparam int Q_MAX       = 32'h7fff_ffff;
  localparam int Q_MIN       = 32'h8000_0000;
  localparam int RAND_BEATS  = 1500;
  localparam int CALM_TAIL   = 150;
  localparam int ROT_STEPS   = 20;
  localparam longint TURN    = 23040;
  localparam longint HALF    = 11520;
  localparam longint QUARTER = 5760;
  localparam longint DEG64_TO_RAD = 74961321;
  localparam longint GAIN_COMP    = 652032874;
  localparam longint ROUND_HALF   = 64'sd536870912;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    req_t beat;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  longint arctan_q30 [0:ROT_STEPS-1] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
  };

  rsp_t     rotated_q[$];
  dir_row_t dir_rows[$];
  int  errors = 0;
  int  beats_sent = 0;
  int  results_checked = 0;
  int  sat_seen = 0;
  int  stall_left = 0;
  bit  gappy = 1'b1;

  axis_rotation_3d dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sine and cosine in Q2.30 after reduction to +-90 degrees
  function automatic void cordic_sincos(input longint ang, output longint s, output longint c);
    longint r, mag, z, x, y, dx, dy;
    bit flip;
    int i;
    r = ang % TURN;
    if (r < 0) r += TURN;
    if (r > HALF) r -= TURN;
    flip = 1'b0;
    if (r > QUARTER) begin
      r -= HALF;
      flip = 1'b1;
    end else if (r < -QUARTER) begin
      r += HALF;
      flip = 1'b1;
    end
    mag = (r < 0) ? -r : r;
    z = (mag * DEG64_TO_RAD + 128) >>> 8;
    if (r < 0) z = -z;
    x = GAIN_COMP;
    y = 0;
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += arctan_q30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint clip_q(input longint v, inout bit sat);
    if (v > longint'(Q_MAX)) begin
      sat = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      sat = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  // p' = p*c - q*s, q' = p*s + q*c
  function automatic void turn_pair(inout longint p, inout longint q, input longint s,
                                    input longint c, inout bit sat);
    longint np, nq;
    np = (p * c - q * s + ROUND_HALF) >>> 30;
    nq = (p * s + q * c + ROUND_HALF) >>> 30;
    p = clip_q(np, sat);
    q = clip_q(nq, sat);
  endfunction

  function automatic rsp_t rotated_vector(input req_t b);
    longint x, y, z, s, c;
    bit sat;
    rsp_t r;
    x = longint'($signed(b.in_x));
    y = longint'($signed(b.in_y));
    z = longint'($signed(b.in_z));
    sat = 1'b0;
    cordic_sincos(longint'($signed(b.angle)), s, c);
    case (b.cmd)
      AXIS_X: turn_pair(y, z, s, c, sat);
      AXIS_Y: turn_pair(z, x, s, c, sat);
      AXIS_Z: turn_pair(x, y, s, c, sat);
      default: ;
    endcase
    r.out_x = x[31:0];
    r.out_y = y[31:0];
    r.out_z = z[31:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic req_t mk_req(input axis_t a, input int x, input int y, input int z,
                                  input shortint ang);
    req_t b;
    b.cmd = a;
    b.in_x = x;
    b.in_y = y;
    b.in_z = z;
    b.angle = ang;
    return b;
  endfunction

  function automatic void add_row(input req_t b, input bit typed, input rsp_t want);
    dir_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return int'($urandom_range(0, 2097152)) - 1048576;
      2: return ($urandom_range(0, 1) != 0) ? Q_MAX - int'($urandom_range(0, 255))
                                            : Q_MIN + int'($urandom_range(0, 255));
      default: return $signed($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  function automatic shortint rand_angle();
    if ($urandom_range(0, 1) != 0) return shortint'($urandom);
    return shortint'((int'($urandom_range(0, 10)) - 5) * 5760 + int'($urandom_range(0, 6)) - 3);
  endfunction

  function automatic req_t random_beat();
    axis_t a;
    if ($urandom_range(0, 9) == 0) a = AXIS_NONE;
    else a = axis_t'($urandom_range(0, 2));
    return mk_req(a, rand_coord(), rand_coord(), rand_coord(), rand_angle());
  endfunction

  task automatic push_beat(input req_t b, input bit typed, input rsp_t want);
    req_valid <= 1'b1;
    req <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    rotated_q.push_back(typed ? want : rotated_vector(b));
    beats_sent++;
  endtask

  task automatic maybe_gap();
    if (gappy && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // response side: checker and stall bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rotated_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result beat %h", rsp);
        end else begin
          rsp_t want;
          want = rotated_q.pop_front();
          results_checked++;
          if (rsp.saturated) sat_seen++;
          if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
              rsp.out_z !== want.out_z || rsp.saturated !== want.saturated) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d: exp x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                       results_checked, want.out_x, want.out_y, want.out_z, want.saturated,
                       rsp.out_x, rsp.out_y, rsp.out_z, rsp.saturated);
          end
        end
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (gappy && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("axis_rotation_3d_tb: done, errors");
    $finish;
  end

  initial begin
    int n;
    add_row(mk_req(AXIS_NONE, Q_MAX, Q_MIN, 12345, 16'sd32767), 1'b1,
            rsp_t'{Q_MAX, Q_MIN, 12345, 1'b0});
    add_row(mk_req(AXIS_NONE, Q_MIN, Q_MAX, -1, -16'sd32768), 1'b1,
            rsp_t'{Q_MIN, Q_MAX, -1, 1'b0});
    add_row(mk_req(AXIS_X, 0, 0, 0, 16'sd1234), 1'b1, rsp_t'{0, 0, 0, 1'b0});
    add_row(mk_req(AXIS_Z, 0, 0, 0, -16'sd32768), 1'b1, rsp_t'{0, 0, 0, 1'b0});
    add_row(mk_req(AXIS_Z, 65536, 0, 0, 16'sd0), 1'b0, '0);
    add_row(mk_req(AXIS_Z, 65536, 0, 0, 16'sd5760), 1'b0, '0);
    add_row(mk_req(AXIS_Z, 65536, 0, 0, -16'sd5760), 1'b0, '0);
    add_row(mk_req(AXIS_Z, 65536, 65536, 0, 16'sd5761), 1'b0, '0);
    add_row(mk_req(AXIS_Z, 65536, 65536, 0, -16'sd5761), 1'b0, '0);
    add_row(mk_req(AXIS_Y, 65536, 0, 65536, 16'sd11520), 1'b0, '0);
    add_row(mk_req(AXIS_Y, 65536, 0, 65536, -16'sd11520), 1'b0, '0);
    add_row(mk_req(AXIS_X, 0, 65536, -65536, 16'sd23040), 1'b0, '0);
    add_row(mk_req(AXIS_X, 0, 65536, -65536, -16'sd23040), 1'b0, '0);
    add_row(mk_req(AXIS_X, 7, Q_MAX, Q_MIN, 16'sd32767), 1'b0, '0);
    add_row(mk_req(AXIS_Y, Q_MIN, 3, Q_MAX, -16'sd32768), 1'b0, '0);
    add_row(mk_req(AXIS_Z, Q_MAX, Q_MAX, Q_MIN, 16'sd2880), 1'b0, '0);
    add_row(mk_req(AXIS_Z, Q_MIN, Q_MIN, Q_MAX, 16'sd2880), 1'b0, '0);
    add_row(mk_req(AXIS_X, -5, Q_MAX, Q_MAX, -16'sd2880), 1'b0, '0);
    add_row(mk_req(AXIS_Y, Q_MIN, 9, Q_MAX, 16'sd8640), 1'b0, '0);
    add_row(mk_req(AXIS_Z, -1, 1, 0, 16'sd11521), 1'b0, '0);
    add_row(mk_req(AXIS_Z, Q_MAX, Q_MIN, 77, -16'sd11521), 1'b0, '0);
    add_row(mk_req(AXIS_X, 1, 2, 3, 16'sd5759), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      maybe_gap();
      push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    for (n = 0; n < RAND_BEATS; n++) begin
      if (n % 64 == 0) gappy = ($urandom_range(0, 2) != 0);
      if (n >= RAND_BEATS - CALM_TAIL) gappy = 1'b0;
      // drain the pipe completely before continuing
      if (n == 500 || n == 1100) begin
        req_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge clk);
      end
      maybe_gap();
      push_beat(random_beat(), 1'b0, '0);
    end

    req_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d beats (%0d directed), checked %0d results, %0d saturated.",
             beats_sent, dir_rows.size(), results_checked, sat_seen);
    $display("Covered all three axes plus pass-through, angle wrap and both idle patterns.");
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("axis_rotation_3d_tb: done, clean");
    end else begin
      $display("Mismatches: %0d, results still pending: %0d", errors, rotated_q.size());
      $display("axis_rotation_3d_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- axis_rotation_3d.f -----
rtl/core/ar3d_pkg.sv
rtl/core/ar3d_angle.sv
rtl/core/ar3d_cell.sv
rtl/core/ar3d_rotate.sv
rtl/core/axis_rotation_3d.sv
sim/axis_rotation_3d_tb.sv
